// File: hw/rtl/cwe_pkg.sv
// shared types, constants and character lookup for the charset word enumerator
// no dependencies; used by scoped names in the front end, back end, top level and testbench

package cwe_pkg;

   localparam int MAX_LENGTH_DEFAULT = 24;
   localparam int QUEUE_DEPTH        = 2;
   localparam int STATUS_LEN_W       = 7;

   localparam logic [6:0] NUM_DIGITS  = 7'd10;
   localparam logic [6:0] NUM_LOWER   = 7'd26;
   localparam logic [6:0] NUM_LETTERS = 7'd52;
   localparam logic [6:0] NUM_SYMBOLS = 7'd23;

   // request codes on the input channel
   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_LENGTH   = 2'd1;
   localparam logic [1:0] REQ_GENERATE = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_DIGITS  = 2'd0;
   localparam logic [1:0] CSR_LETTERS = 2'd1;
   localparam logic [1:0] CSR_SYMBOLS = 2'd2;

   localparam logic [7:0] SYMBOL_CHARS [23] = '{
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h5F,
      8'h2B, 8'h3D, 8'h3B, 8'h3F, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2F
   };

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] position;
      logic [6:0] symbol_index;
      logic [4:0] word_length;
   } req_item_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [4:0] char_position;
      logic       last_char;
      logic       exhausted;
   } rsp_item_type;

   // active character groups, after the digits-only fallback
   typedef struct packed {
      logic use_digits;
      logic use_letters;
      logic use_symbols;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_LENGTH,
      CMD_GENERATE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [4:0]   position;
      logic [6:0]   symbol_index;
      logic [4:0]   word_length;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_GROW
   } back_state_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [STATUS_LEN_W-1:0] length;
   } back_status_type;

   function automatic logic [6:0] set_size(cfg_type cfg);
      logic [6:0] n;
      n = 7'd0;
      if (cfg.use_digits)  n = n + NUM_DIGITS;
      if (cfg.use_letters) n = n + NUM_LETTERS;
      if (cfg.use_symbols) n = n + NUM_SYMBOLS;
      return n;
   endfunction

   // ascii code of entry v of the active set, v already below the set size
   function automatic logic [7:0] char_of(logic [6:0] v, cfg_type cfg);
      logic [6:0] r;
      logic [7:0] code;
      logic       found;
      r     = v;
      code  = 8'h00;
      found = 1'b0;
      if (cfg.use_digits) begin
         if (r < NUM_DIGITS) begin
            code  = 8'h30 + 8'(r);
            found = 1'b1;
         end else begin
            r = r - NUM_DIGITS;
         end
      end
      if (!found && cfg.use_letters) begin
         if (r < NUM_LOWER) begin
            code  = 8'h61 + 8'(r);
            found = 1'b1;
         end else if (r < NUM_LETTERS) begin
            code  = 8'h41 + 8'(r - NUM_LOWER);
            found = 1'b1;
         end else begin
            r = r - NUM_LETTERS;
         end
      end
      if (!found) begin
         if (r >= NUM_SYMBOLS) r = NUM_SYMBOLS - 7'd1;
         code = SYMBOL_CHARS[r[4:0]];
      end
      return code;
   endfunction

endpackage

// File: hw/rtl/cwe_fifo.sv
// small synchronous queue with registered storage
// generic; no package dependencies

module cwe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/cwe_front.sv
// front end: accepts requests, drops meaningless ones, clamps fields, queues commands
// depends on cwe_pkg and cwe_fifo

module cwe_front #(
   parameter int MAX_LENGTH = cwe_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  cwe_pkg::req_item_type req_data,
   output logic                  cmd_valid,
   output cwe_pkg::cmd_type      cmd,
   input  logic                  cmd_pop
);

   localparam int CMD_W = $bits(cwe_pkg::cmd_type);

   cwe_pkg::cmd_type   cmd_new;
   logic               keep;
   logic               q_empty;
   logic [CMD_W-1:0]   q_out;

   always_comb begin
      cmd_new.kind         = cwe_pkg::CMD_GENERATE;
      cmd_new.position     = req_data.position;
      cmd_new.symbol_index = req_data.symbol_index;
      cmd_new.word_length  = req_data.word_length;
      keep                 = 1'b0;
      unique case (req_data.req_type)
         cwe_pkg::REQ_LOAD: begin
            cmd_new.kind = cwe_pkg::CMD_LOAD;
            // loads at or past MAX_LENGTH are dropped
            keep = (int'(req_data.position) < MAX_LENGTH);
         end
         cwe_pkg::REQ_LENGTH: begin
            cmd_new.kind = cwe_pkg::CMD_LENGTH;
            keep         = 1'b1;
            if (req_data.word_length == 5'd0) begin
               cmd_new.word_length = 5'd1;
            end else if (int'(req_data.word_length) > MAX_LENGTH) begin
               cmd_new.word_length = 5'(MAX_LENGTH);
            end
         end
         cwe_pkg::REQ_GENERATE: begin
            cmd_new.kind = cwe_pkg::CMD_GENERATE;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   cwe_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(cwe_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push && !full && keep),
      .push_data(cmd_new),
      .full     (full),
      .pop      (cmd_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = cwe_pkg::cmd_type'(q_out);

endmodule

// File: hw/rtl/cwe_back.sv
// back end: symbol store, odometer sequencer and result queue
// depends on cwe_pkg and cwe_fifo

module cwe_back #(
   parameter int MAX_LENGTH = cwe_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cwe_pkg::cfg_type         cfg,
   input  logic                     cmd_valid,
   input  cwe_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   output logic                     empty,
   input  logic                     pop,
   output cwe_pkg::rsp_item_type    rsp_data,
   output cwe_pkg::back_status_type status
);

   localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam int RSP_W = $bits(cwe_pkg::rsp_item_type);

   cwe_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        pivot_ff, pivot_in;
   logic                    ovf_ff, ovf_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    done_ff, done_in;
   logic [6:0]              sym_ff [MAX_LENGTH];

   logic [6:0]              top_sym;
   logic [6:0]              rd_sym;
   logic [6:0]              rd_clamped;
   logic                    saturated;
   logic                    at_last;
   logic                    at_max;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;
   logic [6:0]              wr_val;
   logic                    out_push;
   logic                    out_full;
   logic [RSP_W-1:0]        out_data;
   cwe_pkg::rsp_item_type   out_item;

   assign top_sym    = cwe_pkg::set_size(cfg) - 7'd1;
   assign rd_sym     = sym_ff[idx_ff];
   assign rd_clamped = (rd_sym > top_sym) ? top_sym : rd_sym;
   assign saturated  = (rd_sym >= top_sym);
   assign at_last    = (idx_ff == IDX_W'(len_ff - LEN_W'(1)));
   assign at_max     = (len_ff == LEN_W'(MAX_LENGTH));

   always_comb begin
      out_item.char_code     = cwe_pkg::char_of(rd_clamped, cfg);
      out_item.char_position = 5'(idx_ff);
      out_item.last_char     = at_last;
      out_item.exhausted     = done_ff || (ovf_ff && at_max);
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pivot_in = pivot_ff;
      ovf_in   = ovf_ff;
      len_in   = len_ff;
      done_in  = done_ff;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = idx_ff;
      wr_val   = rd_sym;
      unique case (state_ff)
         cwe_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  cwe_pkg::CMD_LOAD: begin
                     wr_en  = 1'b1;
                     wr_idx = IDX_W'(cmd.position);
                     wr_val = (cmd.symbol_index > top_sym) ? top_sym : cmd.symbol_index;
                  end
                  cwe_pkg::CMD_LENGTH: begin
                     len_in = LEN_W'(cmd.word_length);
                  end
                  cwe_pkg::CMD_GENERATE: begin
                     idx_in   = IDX_W'(len_ff - LEN_W'(1));
                     state_in = cwe_pkg::ST_SCAN;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         cwe_pkg::ST_SCAN: begin
            // find the rightmost position that does not wrap
            if (!saturated) begin
               pivot_in = idx_ff;
               ovf_in   = 1'b0;
               idx_in   = '0;
               state_in = cwe_pkg::ST_EMIT;
            end else if (idx_ff == '0) begin
               ovf_in   = 1'b1;
               state_in = cwe_pkg::ST_EMIT;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         cwe_pkg::ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               wr_en    = 1'b1;
               if (ovf_ff || idx_ff > pivot_ff) begin
                  wr_val = 7'd0;
               end else if (idx_ff == pivot_ff) begin
                  wr_val = rd_sym + 7'd1;
               end
               if (at_last) begin
                  state_in = ovf_ff ? cwe_pkg::ST_GROW : cwe_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         cwe_pkg::ST_GROW: begin
            if (at_max) begin
               done_in = 1'b1;
            end else begin
               wr_en  = 1'b1;
               wr_idx = IDX_W'(len_ff);
               wr_val = 7'd0;
               len_in = len_ff + LEN_W'(1);
            end
            state_in = cwe_pkg::ST_IDLE;
         end
         default: begin
            state_in = cwe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(1);
         done_ff <= 1'b0;
         for (int i = 0; i < MAX_LENGTH; i++) begin
            sym_ff[i] <= 7'd0;
         end
      end else begin
         len_ff  <= len_in;
         done_ff <= done_in;
         if (wr_en) begin
            sym_ff[wr_idx] <= wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pivot_ff <= pivot_in;
      ovf_ff   <= ovf_in;
   end

   cwe_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(cwe_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .push_data(out_item),
      .full     (out_full),
      .pop      (pop),
      .pop_data (out_data),
      .empty    (empty)
   );

   assign rsp_data = cwe_pkg::rsp_item_type'(out_data);

   always_comb begin
      status.busy   = (state_ff != cwe_pkg::ST_IDLE);
      status.done   = done_ff;
      status.length = cwe_pkg::STATUS_LEN_W'(len_ff);
   end

endmodule

// File: hw/rtl/charset_word_enumerator.sv
// top level of the charset word enumerator: csr registers, front end, back end
// depends on cwe_pkg, cwe_front, cwe_back (and cwe_fifo below them)
// usage
//   requests enter as a queue: req_data is taken when push is high and full low
//   load writes one position's symbol index (clamped to the active set), set
//   length changes the word length (clamped to 1..MAX_LENGTH), generate emits
//   the current word and then steps the odometer; unknown codes are dropped
//   results leave as a queue: rsp_data is valid while empty is low and is taken
//   on pop; a generate gives one transaction per character, leftmost first,
//   with last_char on the final one and exhausted as it stands after the step
// sequencing
//   load and set length are applied in the idle state as the command is popped;
//   generate pops the command, scans leftward from the rightmost position for the
//   rightmost position that does not wrap, emits every character (holding while
//   the result queue is full), then grows the word or ends the keyspace if all wrap
//   a two-entry command queue lets requests arrive while a word is still going
// reset: synchronous; enables return to digits only, every position to symbol 0,
//   length to 1, the exhausted flag clears; both queues empty
// stall: while pop is low the result queue fills and the sequencer holds in place,
//   then the command queue fills and full rises; nothing is dropped

module charset_word_enumerator #(
   parameter int MAX_LENGTH = cwe_pkg::MAX_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  cwe_pkg::req_item_type req_data,
   // result channel
   output logic                  empty,
   input  logic                  pop,
   output cwe_pkg::rsp_item_type rsp_data,
   // csr write port
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic                  csr_write_data
);

   // group enable registers
   logic en_digits_ff, en_digits_in;
   logic en_letters_ff, en_letters_in;
   logic en_symbols_ff, en_symbols_in;

   cwe_pkg::cfg_type         cfg;
   logic                     cmd_valid;
   logic                     cmd_pop;
   cwe_pkg::cmd_type         cmd;
   cwe_pkg::back_status_type status;

   always_comb begin
      en_digits_in  = en_digits_ff;
      en_letters_in = en_letters_ff;
      en_symbols_in = en_symbols_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cwe_pkg::CSR_DIGITS:  en_digits_in  = csr_write_data;
            cwe_pkg::CSR_LETTERS: en_letters_in = csr_write_data;
            cwe_pkg::CSR_SYMBOLS: en_symbols_in = csr_write_data;
            default: begin
               // unused index, write ignored
               en_digits_in = en_digits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_digits_ff  <= 1'b1;
         en_letters_ff <= 1'b0;
         en_symbols_ff <= 1'b0;
      end else begin
         en_digits_ff  <= en_digits_in;
         en_letters_ff <= en_letters_in;
         en_symbols_ff <= en_symbols_in;
      end
   end

   // with every group off the set falls back to digits
   always_comb begin
      cfg.use_digits  = en_digits_ff || (!en_letters_ff && !en_symbols_ff);
      cfg.use_letters = en_letters_ff;
      cfg.use_symbols = en_symbols_ff;
   end

   // front: classify and queue requests
   cwe_front #(
      .MAX_LENGTH(MAX_LENGTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   // back: odometer state and character emission
   cwe_back #(
      .MAX_LENGTH(MAX_LENGTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .status   (status)
   );

   // exhausted is sticky until reset
   a_done_sticky : assert property (@(posedge clock) disable iff (reset)
      status.done |=> status.done)
      else $error("exhausted flag dropped without reset");

   // length never leaves 1..MAX_LENGTH
   a_length_range : assert property (@(posedge clock) disable iff (reset)
      (status.length != '0) &&
      (status.length <= cwe_pkg::STATUS_LEN_W'(MAX_LENGTH)))
      else $error("word length out of range");

   // the keyspace can only run out at full length
   a_done_at_max : assert property (@(posedge clock) disable iff (reset)
      $rose(status.done) |-> (status.length == cwe_pkg::STATUS_LEN_W'(MAX_LENGTH)))
      else $error("exhausted set below maximum length");

endmodule

// File: tb/testbench.sv
// self-checking testbench for charset_word_enumerator: directed table, then random phases
// depends on cwe_pkg and the charset_word_enumerator rtl; needs no other file

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN       = cwe_pkg::MAX_LENGTH_DEFAULT;
   localparam int REQ_W         = $bits(cwe_pkg::req_item_type);
   localparam int PLAN_ROWS     = 24;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 54;
   localparam int SETTLE_CYCLES = 150;
   localparam int PRINT_CAP     = 100;

   // code the block must drop without a trace
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // requested groups, before the digits-only fallback
   typedef struct packed {
      logic digits;
      logic letters;
      logic symbols;
   } charset_sel_type;

   // how the result side paces its pops
   typedef enum logic [1:0] {
      DRAIN_STEADY,
      DRAIN_COIN,
      DRAIN_SPARSE,
      DRAIN_PACED
   } drain_mode_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  push             = 1'b0;
   logic                  full;
   cwe_pkg::req_item_type req_data         = '0;
   logic                  empty;
   logic                  pop              = 1'b0;
   cwe_pkg::rsp_item_type rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [1:0]            csr_index        = cwe_pkg::CSR_DIGITS;
   logic                  csr_write_data   = 1'b0;

   charset_word_enumerator dut (
      .clock,
      .reset,
      .push,
      .full,
      .req_data,
      .empty,
      .pop,
      .rsp_data,
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor state: enables, odometer wheels, length, sticky end flag
   // ---------------------------------------------------------------------
   logic       use_dig = 1'b1;
   logic       use_let = 1'b0;
   logic       use_sym = 1'b0;
   logic [6:0] wheel_sym [MAX_LEN] = '{default: '0};
   logic [4:0] word_len   = 5'd1;
   logic       space_done = 1'b0;

   // full alphabet in set order: digits, lower, upper, symbols
   string charset_text =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_+=;?<>[]{}/";

   // characters still owed by the block, oldest first
   cwe_pkg::rsp_item_type pending_chars [$];

   int fail_count = 0;
   int burst_left = 0;

   // digits count as on when every group is off
   function automatic logic digits_active();
      return use_dig || (!use_let && !use_sym);
   endfunction

   function automatic int charset_size();
      int n;
      n = 0;
      if (digits_active()) n += int'(cwe_pkg::NUM_DIGITS);
      if (use_let)         n += int'(cwe_pkg::NUM_LETTERS);
      if (use_sym)         n += int'(cwe_pkg::NUM_SYMBOLS);
      return n;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_CAP)
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // apply one accepted transaction to the predictor and queue the characters it owes;
   // a non-empty typed word replaces the predicted characters of a generate
   task automatic predict_word(input cwe_pkg::req_item_type item, input string typed);
      cwe_pkg::rsp_item_type word [$];
      cwe_pkg::rsp_item_type one;
      int   n;
      int   v;
      int   idx;
      logic carry;
      n = charset_size();
      case (item.req_type)
         cwe_pkg::REQ_LOAD: begin
            // positions past the wheel count are dropped, big indexes clamp to the top
            if (int'(item.position) < MAX_LEN)
               wheel_sym[item.position] = (int'(item.symbol_index) >= n) ?
                                          7'(n - 1) : item.symbol_index;
         end
         cwe_pkg::REQ_LENGTH: begin
            if (item.word_length == 5'd0)             word_len = 5'd1;
            else if (int'(item.word_length) > MAX_LEN) word_len = 5'(MAX_LEN);
            else                                       word_len = item.word_length;
         end
         cwe_pkg::REQ_GENERATE: begin
            for (int i = 0; i < int'(word_len); i++) begin
               // a wheel left beyond a shrunken set reads as the top symbol
               v = int'(wheel_sym[i]);
               if (v >= n) v = n - 1;
               if (digits_active() && v < int'(cwe_pkg::NUM_DIGITS)) begin
                  idx = v;
               end else begin
                  if (digits_active()) v -= int'(cwe_pkg::NUM_DIGITS);
                  if (use_let && v < int'(cwe_pkg::NUM_LETTERS)) begin
                     idx = int'(cwe_pkg::NUM_DIGITS) + v;
                  end else begin
                     if (use_let) v -= int'(cwe_pkg::NUM_LETTERS);
                     if (v >= int'(cwe_pkg::NUM_SYMBOLS)) v = int'(cwe_pkg::NUM_SYMBOLS) - 1;
                     idx = int'(cwe_pkg::NUM_DIGITS) + int'(cwe_pkg::NUM_LETTERS) + v;
                  end
               end
               one.char_code     = charset_text[idx];
               one.char_position = 5'(i);
               one.last_char     = (i == int'(word_len) - 1);
               one.exhausted     = 1'b0;
               word.push_back(one);
            end
            // odometer step: rightmost wheel first, carry leftward
            carry = 1'b1;
            for (int p = int'(word_len) - 1; p >= 0 && carry; p--) begin
               if (int'(wheel_sym[p]) + 1 < n) begin
                  wheel_sym[p] = wheel_sym[p] + 7'd1;
                  carry = 1'b0;
               end else begin
                  wheel_sym[p] = '0;
               end
            end
            // carry out of the leftmost wheel grows the word, or ends the keyspace
            if (carry) begin
               if (int'(word_len) < MAX_LEN) begin
                  wheel_sym[word_len] = '0;
                  word_len = word_len + 5'd1;
               end else begin
                  space_done = 1'b1;
               end
            end
            // the flag reflects the state after the step, on every character
            foreach (word[i]) word[i].exhausted = space_done;
            if (typed.len() != 0) begin
               word.delete();
               for (int i = 0; i < typed.len(); i++) begin
                  one.char_code     = typed[i];
                  one.char_position = 5'(i);
                  one.last_char     = (i == typed.len() - 1);
                  one.exhausted     = 1'b0;
                  word.push_back(one);
               end
            end
            foreach (word[i]) pending_chars.push_back(word[i]);
         end
         default: ;  // unused code, no effect
      endcase
   endtask

   // hand one transaction to the block; bursts of random length with random gaps
   task automatic offer(input cwe_pkg::req_item_type item, input string typed);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full !== 1'b0);
      predict_word(item, typed);
   endtask

   // one csr write; enable stays high so writes can go back to back
   task automatic csr_put(input logic [1:0] index, input logic value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         cwe_pkg::CSR_DIGITS:  use_dig = value;
         cwe_pkg::CSR_LETTERS: use_let = value;
         cwe_pkg::CSR_SYMBOLS: use_sym = value;
         default: ;
      endcase
   endtask

   // every owed character back, then time for queued loads and lengths to retire
   task automatic wait_drained();
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // directed table, walked in order right after reset (digits only)
   // rows with a typed word are checked against that word, the rest against the predictor
   // ---------------------------------------------------------------------
   cwe_pkg::req_item_type plan_req [PLAN_ROWS] = '{
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},   // fresh reset word
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},   // plain increment
      '{cwe_pkg::REQ_LOAD,     5'd0,  7'd127, 5'd0},   // largest index clamps to the top digit
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},   // top digit, carry grows the word
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_LOAD,     5'd31, 7'd5,   5'd0},   // largest position, dropped
      '{cwe_pkg::REQ_LOAD,     5'd24, 7'd3,   5'd0},   // first position past the wheels
      '{REQ_UNUSED,            5'd31, 7'd127, 5'd31},  // unused code, dropped
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_LENGTH,   5'd0,  7'd0,   5'd0},   // zero length clamps to one
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_LENGTH,   5'd0,  7'd0,   5'd31},  // too long, clamps to the maximum
      '{cwe_pkg::REQ_LOAD,     5'd23, 7'd127, 5'd0},   // last wheel at the top
      '{cwe_pkg::REQ_LOAD,     5'd1,  7'd8,   5'd0},
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},   // full-length word, carry from the right
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_LENGTH,   5'd0,  7'd0,   5'd2},
      '{cwe_pkg::REQ_LOAD,     5'd1,  7'd9,   5'd0},
      '{cwe_pkg::REQ_LOAD,     5'd0,  7'd9,   5'd0},
      '{cwe_pkg::REQ_LOAD,     5'd2,  7'd7,   5'd0},   // wheel beyond the length, zeroed on growth
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},   // carry through every wheel
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0},
      '{cwe_pkg::REQ_GENERATE, 5'd0,  7'd0,   5'd0}
   };

   string plan_word [PLAN_ROWS] = '{
      "0", "1", "", "9", "00", "01", "", "", "", "02", "", "0",
      "", "", "", "", "", "", "", "", "", "99", "000", "001"
   };

   // random phases walk the enables through every mix, both extremes included
   charset_sel_type phase_sel [PHASES] = '{
      '{1'b0, 1'b0, 1'b0},   // nothing on, falls back to digits
      '{1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b1},   // smallest non-digit set
      '{1'b1, 1'b1, 1'b1},   // every group
      '{1'b1, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b1},
      '{1'b1, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b0}
   };

   // phase that drives the keyspace to its end
   localparam int END_PHASE = 5;

   // ---------------------------------------------------------------------
   // result side: check each popped transaction, then pick the next pop
   // ---------------------------------------------------------------------
   drain_mode_type drain_mode = DRAIN_STEADY;
   int             drain_left = 0;
   logic [2:0]     pace_count = '0;

   always @(posedge clock) begin : drain_results
      cwe_pkg::rsp_item_type want;
      if (!reset && pop && empty === 1'b0) begin
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected transaction, char_code", 32'(rsp_data.char_code), '0);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.char_code !== want.char_code)
               report_mismatch("char_code", 32'(rsp_data.char_code), 32'(want.char_code));
            if (rsp_data.char_position !== want.char_position)
               report_mismatch("char_position", 32'(rsp_data.char_position),
                               32'(want.char_position));
            if (rsp_data.last_char !== want.last_char)
               report_mismatch("last_char", 32'(rsp_data.last_char), 32'(want.last_char));
            if (rsp_data.exhausted !== want.exhausted)
               report_mismatch("exhausted", 32'(rsp_data.exhausted), 32'(want.exhausted));
         end
      end
      // switch pacing now and then so stalls land on every part of a word
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(3));
         drain_left = $urandom_range(40, 300);
      end else begin
         drain_left--;
      end
      pace_count <= pace_count + 3'd1;
      case (drain_mode)
         DRAIN_STEADY: pop <= 1'b1;
         DRAIN_COIN:   pop <= 1'($urandom_range(1));
         DRAIN_SPARSE: pop <= ($urandom_range(5) == 0);
         default:      pop <= pace_count[2];
      endcase
   end

   // ---------------------------------------------------------------------
   // stimulus: reset, directed table, random phases, end check
   // ---------------------------------------------------------------------
   initial begin : run_stimulus
      cwe_pkg::req_item_type item;
      int n;
      int sent;
      int roll;
      int pick;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) offer(plan_req[r], plan_word[r]);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         csr_put(cwe_pkg::CSR_DIGITS,  phase_sel[ph].digits);
         csr_put(cwe_pkg::CSR_LETTERS, phase_sel[ph].letters);
         csr_put(cwe_pkg::CSR_SYMBOLS, phase_sel[ph].symbols);
         csr_write_enable <= 1'b0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = charset_size();
            if (ph == END_PHASE && sent == PHASE_ITEMS / 2) begin
               // every wheel at or past the top at full length: the next word ends the keyspace
               item             = REQ_W'($urandom);
               item.req_type    = cwe_pkg::REQ_LENGTH;
               item.word_length = 5'($urandom_range(MAX_LEN, 31));
               offer(item, "");
               for (int p = 0; p < MAX_LEN; p++) begin
                  item              = REQ_W'($urandom);
                  item.req_type     = cwe_pkg::REQ_LOAD;
                  item.position     = 5'(p);
                  item.symbol_index = 7'($urandom_range(n - 1, 127));
                  offer(item, "");
               end
               item          = REQ_W'($urandom);
               item.req_type = cwe_pkg::REQ_GENERATE;
               offer(item, "");
               sent += MAX_LEN + 2;
            end
            // unused fields keep their random bits
            item = REQ_W'($urandom);
            roll = $urandom_range(99);
            pick = $urandom_range(9);
            if (roll < 5) begin
               item.req_type = REQ_UNUSED;
            end else if (roll < 45) begin
               item.req_type = cwe_pkg::REQ_GENERATE;
            end else if (roll < 75) begin
               item.req_type = cwe_pkg::REQ_LOAD;
               // mostly wheels in use, near the top so carries ripple
               if (pick < 7) item.position = 5'($urandom_range(int'(word_len) - 1));
               if (pick < 5)      item.symbol_index = 7'(n - 1 - $urandom_range(1));
               else if (pick < 8) item.symbol_index = 7'($urandom_range(n - 1));
            end else begin
               item.req_type = cwe_pkg::REQ_LENGTH;
               // short words most of the time so growth and carries come often
               if (pick < 7)      item.word_length = 5'($urandom_range(1, 4));
               else if (pick < 8) item.word_length = 5'd0;
               else if (pick < 9) item.word_length = 5'($urandom_range(MAX_LEN + 1, 31));
               else               item.word_length = 5'($urandom_range(1, MAX_LEN));
            end
            offer(item, "");
            if (item.req_type != REQ_UNUSED) sent++;
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
